// ----- hw/rtl/wsh_pkg.sv -----
// ----------------------------------------------------------------------------
// wsh_pkg - shared types and constants of the multimode waveshaper
// Widths, shaping modes, register indexes, stage payloads and the exp(-u) ROM.
// ----------------------------------------------------------------------------
package wsh_pkg;

    // exp(-u) table size: 2^EXP_TABLE_BITS intervals over u in [0, 16)
    localparam int EXP_TABLE_BITS = 8;
    localparam int TAB_N          = 1 << EXP_TABLE_BITS;
    // fraction bits of |x| (Q.15) below one table step
    localparam int FRAC_SHIFT     = 19 - EXP_TABLE_BITS;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    // sample * input gain, signed Q.25
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    // |x| after rounding to Q.15, at most 2^21
    localparam int A_W      = 22;
    localparam int IDX_W    = A_W - FRAC_SHIFT;
    // ROM entries are Q.30, entry 0 is exactly 1.0
    localparam int ROM_W    = 31;
    localparam int TT_W     = 32;

    typedef logic [ROM_W-1:0] t_exp_rom [0:TAB_N];

    // Shaping modes; the remaining codes give the plain gained sample
    typedef enum logic [2:0] {
        MODE_PASS = 3'd0,
        MODE_HARD = 3'd1,
        MODE_QUAD = 3'd2,
        MODE_EXP  = 3'd3,
        MODE_FULL = 3'd4,
        MODE_HALF = 3'd5
    } t_mode;

    // Register indexes of the config port
    typedef enum logic [1:0] {
        CFG_MODE     = 2'd0,
        CFG_IN_GAIN  = 2'd1,
        CFG_OUT_GAIN = 2'd2
    } t_cfg_idx;

    // Region of the quadratic soft clip curve
    typedef enum logic [1:0] {
        Q_LIN  = 2'd0,
        Q_KNEE = 2'd1,
        Q_SAT  = 2'd2
    } t_qcase;

    // Beat leaving the gain stages
    typedef struct packed {
        logic [SAMPLE_W-1:0]   sample;
        logic                  neg;
        logic [A_W-1:0]        mag;
        t_qcase                qcase;
        logic [15:0]           knee_t;
        logic [ROM_W-1:0]      lo;
        logic [ROM_W-1:0]      diff;
        logic [FRAC_SHIFT-1:0] frac;
        logic                  over;
    } t_gain_beat;

    // Beat leaving the shaping stages: sign and magnitude of the shaped value
    typedef struct packed {
        logic           neg;
        logic [A_W-1:0] mag;
    } t_shape_beat;

    // exp(h) in Q.30 as a truncated 24-term Taylor sum, h = 16 / 2^EXP_TABLE_BITS
    localparam logic [63:0] EXP_ONE = 64'd1 << 30;
    localparam logic [63:0] EXP_H   = 64'd1 << (34 - EXP_TABLE_BITS);
    localparam logic [63:0] EXP_T1  = ((EXP_ONE * EXP_H) >> 30) / 64'd1;
    localparam logic [63:0] EXP_T2  = ((EXP_T1 * EXP_H) >> 30) / 64'd2;
    localparam logic [63:0] EXP_T3  = ((EXP_T2 * EXP_H) >> 30) / 64'd3;
    localparam logic [63:0] EXP_T4  = ((EXP_T3 * EXP_H) >> 30) / 64'd4;
    localparam logic [63:0] EXP_T5  = ((EXP_T4 * EXP_H) >> 30) / 64'd5;
    localparam logic [63:0] EXP_T6  = ((EXP_T5 * EXP_H) >> 30) / 64'd6;
    localparam logic [63:0] EXP_T7  = ((EXP_T6 * EXP_H) >> 30) / 64'd7;
    localparam logic [63:0] EXP_T8  = ((EXP_T7 * EXP_H) >> 30) / 64'd8;
    localparam logic [63:0] EXP_T9  = ((EXP_T8 * EXP_H) >> 30) / 64'd9;
    localparam logic [63:0] EXP_T10 = ((EXP_T9 * EXP_H) >> 30) / 64'd10;
    localparam logic [63:0] EXP_T11 = ((EXP_T10 * EXP_H) >> 30) / 64'd11;
    localparam logic [63:0] EXP_T12 = ((EXP_T11 * EXP_H) >> 30) / 64'd12;
    localparam logic [63:0] EXP_T13 = ((EXP_T12 * EXP_H) >> 30) / 64'd13;
    localparam logic [63:0] EXP_T14 = ((EXP_T13 * EXP_H) >> 30) / 64'd14;
    localparam logic [63:0] EXP_T15 = ((EXP_T14 * EXP_H) >> 30) / 64'd15;
    localparam logic [63:0] EXP_T16 = ((EXP_T15 * EXP_H) >> 30) / 64'd16;
    localparam logic [63:0] EXP_T17 = ((EXP_T16 * EXP_H) >> 30) / 64'd17;
    localparam logic [63:0] EXP_T18 = ((EXP_T17 * EXP_H) >> 30) / 64'd18;
    localparam logic [63:0] EXP_T19 = ((EXP_T18 * EXP_H) >> 30) / 64'd19;
    localparam logic [63:0] EXP_T20 = ((EXP_T19 * EXP_H) >> 30) / 64'd20;
    localparam logic [63:0] EXP_T21 = ((EXP_T20 * EXP_H) >> 30) / 64'd21;
    localparam logic [63:0] EXP_T22 = ((EXP_T21 * EXP_H) >> 30) / 64'd22;
    localparam logic [63:0] EXP_T23 = ((EXP_T22 * EXP_H) >> 30) / 64'd23;
    localparam logic [63:0] EXP_SUM = EXP_ONE + EXP_T1 + EXP_T2 + EXP_T3 + EXP_T4
                                    + EXP_T5 + EXP_T6 + EXP_T7 + EXP_T8 + EXP_T9
                                    + EXP_T10 + EXP_T11 + EXP_T12 + EXP_T13
                                    + EXP_T14 + EXP_T15 + EXP_T16 + EXP_T17
                                    + EXP_T18 + EXP_T19 + EXP_T20 + EXP_T21
                                    + EXP_T22 + EXP_T23;
    // exp(-h) in Q.30, rounded reciprocal
    localparam logic [63:0] EXP_R   = ((64'd1 << 60) + (EXP_SUM >> 1)) / EXP_SUM;

    // Builds exp(-i*h) in Q.30 by repeated multiplication with exp(-h)
    function automatic t_exp_rom build_exp_rom();
        t_exp_rom    rom;
        logic [63:0] e;
        int          i;
        e      = EXP_ONE;
        rom[0] = ROM_W'(e);
        for (i = 1; i <= TAB_N; i++) begin
            e      = (e * EXP_R + (64'd1 << 29)) >> 30;
            rom[i] = ROM_W'(e);
        end
        return rom;
    endfunction

    localparam t_exp_rom EXP_ROM = build_exp_rom();

endpackage

// ----- hw/rtl/wsh_gain.sv -----
// ----------------------------------------------------------------------------
// wsh_gain - input gain and curve preparation
// Stage 1 multiplies the sample by the input gain. Stage 2 rounds to Q.15,
// splits sign and magnitude, sorts the quadratic region and reads the ROM.
// ----------------------------------------------------------------------------
module wsh_gain (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [wsh_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [wsh_pkg::GAIN_W-1:0]          i_gain,
    output logic                               o_valid,
    input  logic                               i_ready,
    output wsh_pkg::t_gain_beat                 o_beat
);

    localparam int ETB = wsh_pkg::EXP_TABLE_BITS;
    localparam int FS  = wsh_pkg::FRAC_SHIFT;
    localparam int AW  = wsh_pkg::A_W;

    logic                                r_v1;
    logic                                r_v2;
    logic signed [wsh_pkg::SAMPLE_W-1:0]  r_s1_sample;
    logic signed [wsh_pkg::PROD_W-1:0]    r_s1_g;
    wsh_pkg::t_gain_beat                  r_s2;
    wsh_pkg::t_gain_beat                  n_s2;
    logic signed [wsh_pkg::PROD_W-1:0]    n_g;
    logic                                rdy1;
    logic                                rdy2;

    logic                                gneg;
    logic [wsh_pkg::PROD_W-2:0]           gmag;
    logic [wsh_pkg::PROD_W-1:0]           grnd;
    logic [AW-1:0]                       amag;
    logic [AW+1:0]                       a3;
    logic [wsh_pkg::IDX_W-1:0]            idx;
    logic [ETB:0]                        lo_i;
    logic [ETB:0]                        hi_i;
    logic [wsh_pkg::ROM_W-1:0]            lo;
    logic [wsh_pkg::ROM_W-1:0]            hi;

    // stage readiness: a stage moves when empty or when the next one moves
    assign rdy2    = !r_v2 || i_ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v2;
    assign o_beat  = r_s2;

    // stage 1: sample times Q6.10 gain, signed Q.25
    assign n_g = wsh_pkg::PROD_W'(i_sample) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_sample <= i_sample;
            r_s1_g      <= n_g;
        end
    end

    // stage 2: round half away from zero to Q.15, then curve lookups
    always_comb begin
        gneg = r_s1_g[wsh_pkg::PROD_W-1];
        gmag = (wsh_pkg::PROD_W-1)'(gneg ? -r_s1_g : r_s1_g);
        grnd = {1'b0, gmag} + wsh_pkg::PROD_W'(512);
        amag = AW'(grnd >> 10);
        a3   = {2'b00, amag} + {1'b0, amag, 1'b0};

        n_s2.sample = r_s1_sample;
        n_s2.neg    = gneg;
        n_s2.mag    = amag;
        n_s2.knee_t = 16'(a3);
        // quadratic region from 3|x| against 2.0 and 1.0
        priority if (a3 > (AW+2)'(65536)) begin
            n_s2.qcase  = wsh_pkg::Q_SAT;
        end else if (a3 > (AW+2)'(32768)) begin
            n_s2.qcase  = wsh_pkg::Q_KNEE;
            n_s2.knee_t = 16'((AW+2)'(65536) - a3);
        end else begin
            n_s2.qcase  = wsh_pkg::Q_LIN;
        end

        // table neighbours around |x|
        idx  = amag[AW-1:FS];
        lo_i = {1'b0, idx[ETB-1:0]};
        hi_i = lo_i + (ETB+1)'(1);
        lo   = wsh_pkg::EXP_ROM[lo_i];
        hi   = wsh_pkg::EXP_ROM[hi_i];
        n_s2.lo   = lo;
        n_s2.diff = (lo >= hi) ? (lo - hi) : '0;
        n_s2.frac = amag[FS-1:0];
        n_s2.over = |idx[wsh_pkg::IDX_W-1:ETB];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2 <= n_s2;
        end
    end

endmodule

// ----- hw/rtl/wsh_shape.sv -----
// ----------------------------------------------------------------------------
// wsh_shape - curve evaluation
// Stage 3 squares the knee term and scales the table step by the fraction.
// Stage 4 finishes both soft clip curves and selects by the shaping mode.
// ----------------------------------------------------------------------------
module wsh_shape (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [2:0]          i_mode,
    input  logic                i_valid,
    output logic                o_ready,
    input  wsh_pkg::t_gain_beat  i_beat,
    output logic                o_valid,
    input  logic                i_ready,
    output wsh_pkg::t_shape_beat o_beat
);

    localparam int FS    = wsh_pkg::FRAC_SHIFT;
    localparam int AW    = wsh_pkg::A_W;
    localparam int RW    = wsh_pkg::ROM_W;
    localparam int TTW   = wsh_pkg::TT_W;
    localparam int M_W   = 17;
    // ceil(2^17 / 3): exact floor(m / 3) for m below 2^17
    localparam int RECIP_3 = 43691;

    typedef struct packed {
        logic [wsh_pkg::SAMPLE_W-1:0] sample;
        logic                        neg;
        logic [AW-1:0]               mag;
        wsh_pkg::t_qcase              qcase;
        logic [TTW-1:0]              tt;
        logic [RW-1:0]               lo;
        logic [RW-1:0]               step;
        logic                        over;
    } t_s3;

    t_s3                  r_s3;
    t_s3                  n_s3;
    wsh_pkg::t_shape_beat  r_s4;
    wsh_pkg::t_shape_beat  n_s4;
    logic                 r_v3;
    logic                 r_v4;
    logic                 rdy3;
    logic                 rdy4;

    logic [RW+FS-1:0]     dprod;
    logic [TTW-1:0]       num;
    logic [TTW:0]         num_r;
    logic [M_W-1:0]       m;
    logic [M_W+15:0]      mq;
    logic [AW-1:0]        qmag;
    logic [RW-1:0]        e;
    logic [TTW-1:0]       ev;
    logic [AW-1:0]        emag;
    logic signed [wsh_pkg::SAMPLE_W-1:0] s_in;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign o_ready = rdy3;
    assign o_valid = r_v4;
    assign o_beat  = r_s4;

    // stage 3: the two curve multiplies
    always_comb begin
        dprod       = (RW+FS)'(i_beat.diff) * (RW+FS)'(i_beat.frac);
        n_s3.sample = i_beat.sample;
        n_s3.neg    = i_beat.neg;
        n_s3.mag    = i_beat.mag;
        n_s3.qcase  = i_beat.qcase;
        n_s3.tt     = TTW'(i_beat.knee_t) * TTW'(i_beat.knee_t);
        n_s3.lo     = i_beat.lo;
        n_s3.step   = RW'(dprod >> FS);
        n_s3.over   = i_beat.over;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3 <= n_s3;
        end
    end

    // stage 4: finish curves, select by mode
    always_comb begin
        // quadratic knee: (3*2^30 - t^2) / 98304, half up, as (n >> 15) / 3
        num   = TTW'(64'd3 << 30) - r_s3.tt;
        num_r = {1'b0, num} + (TTW+1)'(49152);
        m     = M_W'(num_r >> 15);
        mq    = (M_W+16)'(m) * (M_W+16)'(RECIP_3);
        unique case (r_s3.qcase)
            wsh_pkg::Q_SAT:  qmag = AW'(32768);
            wsh_pkg::Q_KNEE: qmag = AW'(mq >> 17);
            default:         qmag = {r_s3.mag[AW-2:0], 1'b0};
        endcase

        // exponential: 1 - exp(-|x|), exp taken as 0 beyond the table
        e    = r_s3.over ? '0 : (r_s3.lo - r_s3.step);
        ev   = TTW'(64'd1 << 30) - TTW'(e) + TTW'(16384);
        emag = AW'(ev >> 15);

        s_in     = r_s3.sample;
        n_s4.neg = r_s3.neg;
        unique case (i_mode)
            wsh_pkg::MODE_PASS: begin
                n_s4.neg = s_in[wsh_pkg::SAMPLE_W-1];
                n_s4.mag = AW'(s_in[wsh_pkg::SAMPLE_W-1] ? -32'(s_in) : 32'(s_in));
            end
            wsh_pkg::MODE_HARD: begin
                n_s4.mag = (r_s3.mag > AW'(32768)) ? AW'(32768) : r_s3.mag;
            end
            wsh_pkg::MODE_QUAD: begin
                n_s4.mag = qmag;
            end
            wsh_pkg::MODE_EXP: begin
                n_s4.mag = emag;
            end
            wsh_pkg::MODE_FULL: begin
                n_s4.neg = 1'b0;
                n_s4.mag = r_s3.mag;
            end
            wsh_pkg::MODE_HALF: begin
                n_s4.neg = 1'b0;
                n_s4.mag = r_s3.neg ? '0 : r_s3.mag;
            end
            default: begin
                n_s4.mag = r_s3.mag;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (rdy4) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4 <= n_s4;
        end
    end

endmodule

// ----- hw/rtl/wsh_out.sv -----
// ----------------------------------------------------------------------------
// wsh_out - output gain and saturation
// Stage 5 multiplies the shaped magnitude by the Q4.12 output gain. Stage 6
// rounds to Q.15, restores the sign, clamps to 16 bits and flags the clamp.
// ----------------------------------------------------------------------------
module wsh_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [wsh_pkg::GAIN_W-1:0]          i_gain,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  wsh_pkg::t_shape_beat                i_beat,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [wsh_pkg::SAMPLE_W-1:0] o_sample,
    output logic                               o_sat
);

    localparam int P_W = wsh_pkg::A_W + wsh_pkg::GAIN_W;
    localparam int R_W = P_W - 12 + 1;

    logic                                r_v5;
    logic                                r_v6;
    logic                                r_s5_neg;
    logic [P_W-1:0]                      r_s5_p;
    logic signed [wsh_pkg::SAMPLE_W-1:0]  r_sample;
    logic                                r_sat;
    logic signed [wsh_pkg::SAMPLE_W-1:0]  n_sample;
    logic                                n_sat;
    logic [R_W-1:0]                      rmag;
    logic                                rdy5;
    logic                                rdy6;

    assign rdy6     = !r_v6 || i_ready;
    assign rdy5     = !r_v5 || rdy6;
    assign o_ready  = rdy5;
    assign o_valid  = r_v6;
    assign o_sample = r_sample;
    assign o_sat    = r_sat;

    // stage 5: magnitude times output gain, Q.27
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (rdy5) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy5) begin
            r_s5_neg <= i_beat.neg;
            r_s5_p   <= P_W'(i_beat.mag) * P_W'(i_gain);
        end
    end

    // stage 6: round half away from zero, then clamp
    always_comb begin
        rmag = R_W'(({1'b0, r_s5_p} + (P_W+1)'(2048)) >> 12);
        n_sat = 1'b0;
        priority if (!r_s5_neg && rmag > R_W'(32767)) begin
            n_sample = 16'sh7FFF;
            n_sat    = 1'b1;
        end else if (r_s5_neg && rmag > R_W'(32768)) begin
            n_sample = -16'sh8000;
            n_sat    = 1'b1;
        end else if (r_s5_neg) begin
            n_sample = wsh_pkg::SAMPLE_W'(-rmag);
        end else begin
            n_sample = wsh_pkg::SAMPLE_W'(rmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (rdy6) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_sample <= n_sample;
            r_sat    <= n_sat;
        end
    end

endmodule

// ----- hw/rtl/multimode_waveshaper.sv -----
// ----------------------------------------------------------------------------
// multimode_waveshaper - gain, waveshaping and output gain for Q1.15 audio
// Input gain, one of six shaping curves, output gain with 16-bit saturation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                   Beat
// in        in         i_in_valid / o_in_stall     i_sample_in
// out       out        o_out_valid / i_out_stall   o_sample_out, o_saturated
// cfg       in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Six register stages; one sample per cycle while the output is not stalled.
// The input gain multiply, the knee square with the table step and the output
// gain multiply sit in stages 1, 3 and 5; the exp(-u) table is a constant ROM.
// Every stage holds its beat under stall and fills its bubbles, so input is
// taken while results wait as long as a stage is empty. Synchronous reset
// clears the valid bits and sets mode 0, input gain 1.0 and output gain 1.0;
// the config port never stalls.
// ----------------------------------------------------------------------------
module multimode_waveshaper (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [wsh_pkg::SAMPLE_W-1:0] i_sample_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [wsh_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                               o_saturated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [wsh_pkg::GAIN_W-1:0]          i_cfg_data
);

    logic [2:0]                 r_mode;
    logic [wsh_pkg::GAIN_W-1:0]  r_in_gain;
    logic [wsh_pkg::GAIN_W-1:0]  r_out_gain;

    logic                       gain_ready;
    logic                       gain_valid;
    wsh_pkg::t_gain_beat         gain_beat;
    logic                       shape_ready;
    logic                       shape_valid;
    wsh_pkg::t_shape_beat        shape_beat;
    logic                       out_ready;

    // config registers, written on a cfg beat with index 0 to 2
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= wsh_pkg::MODE_PASS;
            r_in_gain  <= wsh_pkg::GAIN_W'(1024);
            r_out_gain <= wsh_pkg::GAIN_W'(4096);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                wsh_pkg::CFG_MODE:     r_mode     <= i_cfg_data[2:0];
                wsh_pkg::CFG_IN_GAIN:  r_in_gain  <= i_cfg_data;
                wsh_pkg::CFG_OUT_GAIN: r_out_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_stall = !gain_ready;

    // stages 1-2
    wsh_gain u_gain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (gain_ready),
        .i_sample (i_sample_in),
        .i_gain   (r_in_gain),
        .o_valid  (gain_valid),
        .i_ready  (shape_ready),
        .o_beat   (gain_beat)
    );

    // stages 3-4
    wsh_shape u_shape (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_valid  (gain_valid),
        .o_ready  (shape_ready),
        .i_beat   (gain_beat),
        .o_valid  (shape_valid),
        .i_ready  (out_ready),
        .o_beat   (shape_beat)
    );

    // stages 5-6
    wsh_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_gain   (r_out_gain),
        .i_valid  (shape_valid),
        .o_ready  (out_ready),
        .i_beat   (shape_beat),
        .o_valid  (o_out_valid),
        .i_ready  (!i_out_stall),
        .o_sample (o_sample_out),
        .o_sat    (o_saturated)
    );

endmodule
